FILE: rtl/core/lz77td_pkg.sv
`timescale 1ns / 1ps

package lz77td_pkg;

  // Token field widths
  localparam int DIST_W = 8;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;

  // Byte lanes in one result beat, and the width of the lane count field
  localparam int LANES     = 4;
  localparam int LANE_IX_W = 2;
  localparam int COUNT_W   = 3;

  // Width for ring address arithmetic: one bit above the distance field
  localparam int SUM_W = DIST_W + 1;

  // Packed widths of the stream ports
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - LANES * BYTE_W - COUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FLUSH
  } state_t;

endpackage

FILE: rtl/core/lz77_triple_decoder_top.sv
`timescale 1ns / 1ps
// A literal token is held in the lane register, then in the output register, and leaves as one beat.
// A match reads then appends each byte and flushes each beat; a held output beat stalls it.
// Throughput: one token at a time; each copied byte costs one ring read and one ring append,
// set by the single read-then-write loop through the history memory.
// Reset (rst_n, synchronous, active low) clears the sequencer, ring pointer, fill level and the
// output valid flag; the history memory is not cleared and needs no clearing pass.
module lz77_triple_decoder_top #(
  parameter int WINDOW     = 255,
  parameter int BEAT_BYTES = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Token input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: back_distance [7:0], copy_length [15:8], literal_byte [23:16]
  input  logic [lz77td_pkg::IN_DATA_W-1:0]   in_tdata,
  // Decoded output beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: out_byte0 [7:0], out_byte1 [15:8], out_byte2 [23:16], out_byte3 [31:24],
  //            byte_count [34:32], zero pad [39:35]
  output logic [lz77td_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: bad_distance [0]
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import lz77td_pkg::*;

  // Ring address and fill-level widths follow the window size
  localparam int ADDR_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  // Beats never carry more than the four byte fields
  localparam int LANE_LIMIT = (BEAT_BYTES < LANES) ? BEAT_BYTES : LANES;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;       // bytes still to copy
  logic [ADDR_W-1:0]   wp_r, wp_nxt;         // next ring slot to write
  logic [CNT_W-1:0]    held_r, held_nxt;     // valid bytes in the ring
  logic [COUNT_W-1:0]  fill_r, fill_nxt;     // bytes gathered for the current beat
  logic                bad_r, bad_nxt;
  logic [BYTE_W-1:0]   lane_r   [LANES];
  logic [BYTE_W-1:0]   lane_nxt [LANES];

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_bad_r, out_bad_nxt;
  logic                    out_last_r, out_last_nxt;

  // History ring, one write and one registered read port
  logic [BYTE_W-1:0]   hist_mem [WINDOW];
  logic [BYTE_W-1:0]   rd_data_r;
  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   wr_data;

  // Token fields
  logic [DIST_W-1:0]   tok_dist;
  logic [LEN_W-1:0]    tok_len;
  logic [BYTE_W-1:0]   tok_lit;

  logic                in_acc;
  logic                out_free;
  logic                beat_done;
  logic [SUM_W-1:0]    wp_ext, dist_ext, back_addr;
  logic [COUNT_W-1:0]  fill_inc;

  assign tok_dist = in_tdata[DIST_W-1:0];
  assign tok_len  = in_tdata[DIST_W +: LEN_W];
  assign tok_lit  = in_tdata[DIST_W + LEN_W +: BYTE_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;
  assign out_tlast  = out_last_r;

  // Address unit: step back dist_r slots from the write pointer, wrapping at WINDOW
  assign wp_ext   = SUM_W'(wp_r);
  assign dist_ext = SUM_W'(dist_r);
  always_comb begin
    if (wp_ext >= dist_ext) begin
      back_addr = wp_ext - dist_ext;
    end else begin
      back_addr = wp_ext + SUM_W'(WINDOW) - dist_ext;
    end
  end

  assign fill_inc  = fill_r + COUNT_W'(1);
  assign beat_done = (fill_inc == COUNT_W'(LANE_LIMIT)) || (len_r == LEN_W'(1));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (tok_dist == '0) begin
            state_nxt = ST_FLUSH;
          end else if (tok_len == '0) begin
            state_nxt = ST_IDLE;
          end else if (SUM_W'(tok_dist) > SUM_W'(held_r)) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = beat_done ? ST_FLUSH : ST_READ;
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = (len_r == '0) ? ST_IDLE : ST_READ;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    dist_nxt      = dist_r;
    len_nxt       = len_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    fill_nxt      = fill_r;
    bad_nxt       = bad_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = back_addr[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_data       = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dist_nxt = tok_dist;
          len_nxt  = tok_len;
          fill_nxt = '0;
          bad_nxt  = 1'b0;
          if (tok_dist == '0) begin
            // Literal: append and hold it as a one-byte beat
            wr_en       = 1'b1;
            wr_data     = tok_lit;
            lane_nxt[0] = tok_lit;
            fill_nxt    = COUNT_W'(1);
            len_nxt     = '0;
          end else if (tok_len != '0 && SUM_W'(tok_dist) > SUM_W'(held_r)) begin
            // Distance reaches past the held bytes: drop, report once
            bad_nxt = 1'b1;
            len_nxt = '0;
          end
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_WRITE: begin
        wr_en                         = 1'b1;
        lane_nxt[fill_r[LANE_IX_W-1:0]] = rd_data_r;
        fill_nxt                      = fill_inc;
        len_nxt                       = len_r - LEN_W'(1);
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          out_last_nxt  = (len_r == '0);
          out_data_nxt  = '0;
          for (int i = 0; i < LANES; i++) begin
            if (COUNT_W'(i) < fill_r) begin
              out_data_nxt[i*BYTE_W +: BYTE_W] = lane_r[i];
            end
          end
          out_data_nxt[LANES*BYTE_W +: COUNT_W] = fill_r;
          fill_nxt = '0;
        end
      end
      default: ;
    endcase

    // Every append advances the write pointer and the saturating fill level
    if (wr_en) begin
      wp_nxt = (wp_r == ADDR_W'(WINDOW - 1)) ? '0 : wp_r + ADDR_W'(1);
      if (held_r < CNT_W'(WINDOW)) begin
        held_nxt = held_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      held_r      <= '0;
      fill_r      <= '0;
      len_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    lane_r     <= lane_nxt;
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
    out_last_r <= out_last_nxt;
  end

  // History memory: write at the ring pointer, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A copy never reads a ring slot that was not written
  a_read_in_history: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (dist_r != '0 && SUM_W'(dist_r) <= SUM_W'(held_r)))
    else $error("copy distance beyond held history");

  // Pointer stays inside the ring and the fill level never passes the window
  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W'(wp_r) < SUM_W'(WINDOW)) && (SUM_W'(held_r) <= SUM_W'(WINDOW)))
    else $error("ring pointer or fill level out of range");

  // A dropped token leaves one empty, final beat
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata[LANES*BYTE_W +: COUNT_W] == '0))
    else $error("bad-distance beat is not empty and final");

  // Beats carry between one and LANE_LIMIT bytes unless dropped
  a_beat_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[LANES*BYTE_W +: COUNT_W] != '0 &&
       out_tdata[LANES*BYTE_W +: COUNT_W] <= COUNT_W'(LANE_LIMIT)))
    else $error("beat byte count out of range");

  // An append during a copy shifts the write pointer by one slot
  a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> (wp_r == (($past(wp_r) == ADDR_W'(WINDOW - 1)) ?
                                         '0 : $past(wp_r) + ADDR_W'(1))))
    else $error("write pointer did not advance on append");

endmodule

FILE: bench/lz77_triple_decoder_checker.sv
`timescale 1ns / 1ps

module lz77_triple_decoder_checker #(
  parameter int WINDOW = 255
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [lz77td_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [lz77td_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                              out_tuser,
  input  logic                              out_tlast,
  output int                                fail_count,
  output int                                beats_owed,
  output int                                beats_checked
);
  import lz77td_pkg::*;

  typedef struct packed {
    logic                          bad;
    logic                          last;
    logic [COUNT_W-1:0]            count;
    logic [LANES-1:0][BYTE_W-1:0]  lanes;
  } beat_t;

  beat_t owed_beats[$];

  logic [BYTE_W-1:0] ring [WINDOW];
  int                ring_wr;
  int                ring_fill;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("MISMATCH beat %0d at %0t: %s got %0h want %0h",
               beats_checked, $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void append_history(input logic [BYTE_W-1:0] b);
    ring[ring_wr] = b;
    ring_wr = (ring_wr + 1) % WINDOW;
    if (ring_fill < WINDOW)
      ring_fill++;
  endfunction

  // Work out the beats one token must produce and queue them.
  task automatic decode_token(input logic [IN_DATA_W-1:0] tok);
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    logic [BYTE_W-1:0] b;
    beat_t             bt;
    int                fill;
    int                rd;
    int                j;
    back_dist = tok[DIST_W-1:0];
    len       = tok[DIST_W +: LEN_W];
    lit       = tok[DIST_W+LEN_W +: BYTE_W];
    bt        = '0;
    fill      = 0;
    if (back_dist == '0) begin
      bt.lanes[0] = lit;
      bt.count    = COUNT_W'(1);
      bt.last     = 1'b1;
      append_history(lit);
      owed_beats.push_back(bt);
    end else if (len == '0) begin
      // empty copy: nothing leaves, history untouched
    end else if (int'(back_dist) > ring_fill) begin
      bt.bad  = 1'b1;
      bt.last = 1'b1;
      owed_beats.push_back(bt);
    end else begin
      for (j = 0; j < int'(len); j++) begin
        rd = (ring_wr + WINDOW - int'(back_dist)) % WINDOW;
        b  = ring[rd];
        append_history(b);
        bt.lanes[fill] = b;
        fill++;
        if (fill == LANES || j + 1 == int'(len)) begin
          bt.count = COUNT_W'(fill);
          bt.last  = (j + 1 == int'(len));
          owed_beats.push_back(bt);
          bt   = '0;
          fill = 0;
        end
      end
    end
  endtask

  task automatic compare_beat();
    beat_t got;
    beat_t want;
    int    k;
    got.lanes = out_tdata[LANES*BYTE_W-1:0];
    got.count = out_tdata[LANES*BYTE_W +: COUNT_W];
    got.bad   = out_tuser;
    got.last  = out_tlast;
    beats_checked++;
    if (out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0)
      report_mismatch("pad bits", 32'(out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]), '0);
    if (owed_beats.size() == 0) begin
      report_mismatch("unexpected beat, lanes", got.lanes, '0);
      return;
    end
    want = owed_beats.pop_front();
    for (k = 0; k < LANES; k++)
      if (got.lanes[k] !== want.lanes[k])
        report_mismatch($sformatf("out_byte%0d", k), 32'(got.lanes[k]), 32'(want.lanes[k]));
    if (got.count !== want.count)
      report_mismatch("byte_count", 32'(got.count), 32'(want.count));
    if (got.last !== want.last)
      report_mismatch("last_beat", 32'(got.last), 32'(want.last));
    if (got.bad !== want.bad)
      report_mismatch("bad_distance", 32'(got.bad), 32'(want.bad));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_beats.delete();
      ring_wr       = 0;
      ring_fill     = 0;
      fail_count    = 0;
      beats_checked = 0;
    end else begin
      if (out_tvalid && out_tready)
        compare_beat();
      if (in_tvalid && in_tready)
        decode_token(in_tdata);
    end
    beats_owed = owed_beats.size();
  end

endmodule

FILE: bench/tb_lz77_triple_decoder_top.sv
`timescale 1ns / 1ps

module tb_lz77_triple_decoder_top;
  import lz77td_pkg::*;

  localparam int WINDOW     = 255;
  localparam int RAND_ITEMS = 440;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata: back_distance [7:0], copy_length [15:8], literal_byte [23:16]
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata: out_byte0..out_byte3 [31:0], byte_count [34:32], zero pad [39:35]
  logic [OUT_DATA_W-1:0] out_tdata;
  // out_tuser: bad_distance [0]
  logic                  out_tuser;
  logic                  out_tlast;

  int fail_count;
  int beats_owed;
  int beats_checked;

  // Stimulus-side tally of bytes held in the ring, so that distances can be
  // aimed inside or just beyond the history.
  int   held_tally;
  int   n_literal;
  int   n_copy;
  int   n_refused;
  int   n_empty;
  logic tx_burst;
  logic rx_burst;

  lz77_triple_decoder_top #(
    .WINDOW     (WINDOW),
    .BEAT_BYTES (4)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lz77_triple_decoder_checker #(
    .WINDOW (WINDOW)
  ) decode_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .beats_owed    (beats_owed),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one token, after a random gap unless in a burst stretch. Valid is
  // only dropped when a gap follows, so a back-to-back item never sees valid
  // lowered and raised in the same step.
  task automatic send_token(input logic [DIST_W-1:0] back_dist, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lit, len, back_dist};
    do @(posedge clk); while (!in_tready);
    // classify the accepted item and advance the held tally
    if (back_dist == '0) begin
      n_literal++;
      held_tally = (held_tally < WINDOW) ? held_tally + 1 : WINDOW;
    end else if (len == '0) begin
      n_empty++;
    end else if (int'(back_dist) > held_tally) begin
      n_refused++;
    end else begin
      n_copy++;
      held_tally = (held_tally + int'(len) < WINDOW) ? held_tally + int'(len) : WINDOW;
    end
  endtask

  // Mostly short copies, some medium, a few long ones up to the longest.
  function automatic logic [LEN_W-1:0] draw_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return LEN_W'($urandom_range(1, 8));
    else if (pick < 95)
      return LEN_W'($urandom_range(9, 40));
    return LEN_W'($urandom_range(41, 255));
  endfunction

  // Random token: mostly literals and in-range copies with random content,
  // the rest empty copies and distances beyond the history.
  task automatic random_token();
    int                pick;
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] lit;
    pick      = $urandom_range(0, 99);
    lit       = BYTE_W'($urandom);
    len       = LEN_W'($urandom);
    back_dist = '0;
    if (pick < 30 || held_tally == 0) begin
      back_dist = '0;
    end else if (pick < 88) begin
      back_dist = ($urandom_range(0, 4) == 0) ? DIST_W'(held_tally)
                                              : DIST_W'($urandom_range(1, held_tally));
      len       = draw_length();
    end else if (pick < 94) begin
      back_dist = DIST_W'($urandom_range(1, 255));
      len       = '0;
    end else begin
      // beyond the history while it is still filling; a plain copy after that
      back_dist = (held_tally < WINDOW) ? DIST_W'($urandom_range(held_tally + 1, 255))
                                        : DIST_W'($urandom_range(1, 255));
      len       = draw_length();
    end
    send_token(back_dist, len, lit);
  endtask

  // Result side: draw a stall for every beat, with stretches of none.
  initial begin : result_sink
    int stall;
    int beats_since;
    out_tready  = 1'b0;
    rx_burst    = 1'b0;
    beats_since = 0;
    forever begin
      if (beats_since == 25) begin
        rx_burst    = ($urandom_range(0, 3) == 0);
        beats_since = 0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      beats_since++;
    end
  end

  initial begin : stimulus
    int i;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    tx_burst   = 1'b0;
    held_tally = 0;
    n_literal  = 0;
    n_copy     = 0;
    n_refused  = 0;
    n_empty    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty history refuses any copy
    send_token(8'd1,   8'd1,   8'h00);
    send_token(8'd255, 8'd255, 8'hFF);
    // zero length with a bad distance gives nothing
    send_token(8'd200, 8'd0,   8'h33);
    // literals at the byte extremes, length field ignored
    send_token(8'd0,   8'd0,   8'h00);
    send_token(8'd0,   8'd255, 8'hFF);
    send_token(8'd0,   8'h5A,  8'hA5);
    send_token(8'd0,   8'hA5,  8'h5A);
    // one beyond the four bytes held
    send_token(8'd5,   8'd1,   8'h77);
    // whole-beat copy, literal ignored; then overlapping runs
    send_token(8'd4,   8'd4,   8'hFF);
    send_token(8'd1,   8'd7,   8'h11);
    send_token(8'd3,   8'd5,   8'h00);
    send_token(8'd2,   8'd0,   8'h00);
    send_token(8'd1,   8'd1,   8'h00);
    // farthest byte held, then the longest copy fills the ring
    send_token(8'(held_tally), 8'd3, 8'h3C);
    send_token(8'd1,   8'd255, 8'hC3);
    // full ring: farthest distance, short and longest
    send_token(8'd255, 8'd3,   8'h00);
    send_token(8'd255, 8'd255, 8'h96);
    send_token(8'd128, 8'd9,   8'h42);
    send_token(8'd0,   8'd0,   8'h81);
    send_token(8'd255, 8'd0,   8'hE7);

    // Random: alternate gappy and back-to-back stretches
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0)
        tx_burst = ($urandom_range(0, 3) == 0);
      random_token();
    end
    in_tvalid <= 1'b0;

    // Drain: let the checker take the last item, hold until every owed beat
    // is in, then watch a while longer for stray beats
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (700) @(posedge clk);

    $display("Covered %0d tokens: %0d literal, %0d copy, %0d out-of-range, %0d zero-length;",
             n_literal + n_copy + n_refused + n_empty, n_literal, n_copy, n_refused, n_empty);
    $display("%0d output beats compared, %0d mismatches.", beats_checked, fail_count);
    if (fail_count == 0) begin
      $display("lz77_triple_decoder_top verification clean");
    end else begin
      $display("lz77_triple_decoder_top verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run with every stall at its longest
  initial begin : watchdog
    #8_000_000;
    $display("Timed out with %0d beats still owed.", beats_owed);
    $display("lz77_triple_decoder_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lz77td_pkg.sv
rtl/core/lz77_triple_decoder_top.sv
bench/lz77_triple_decoder_checker.sv
bench/tb_lz77_triple_decoder_top.sv
